// File: hw/rtl/acl_fragment_reassembly_unit_assert.svh
// Assertion macros shared by the reassembly unit modules.
`ifndef ACL_FRAGMENT_REASSEMBLY_UNIT_ASSERT_SVH
`define ACL_FRAGMENT_REASSEMBLY_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the module clock, off during reset.
`define AFR_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the module clock, off during reset.
`define AFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/acl_fr_pkg.sv
// Shared types and constants of the ACL fragment reassembly unit.
`timescale 1ns / 1ps

package acl_fr_pkg;

   localparam int unsigned LINK_SLOTS_DEFAULT = 3;
   localparam logic [15:0] MIN_RX_LEN = 16'd27;
   localparam logic [15:0] L2_HDR_LEN = 16'd4;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_FRAGMENT = 2'd0;
   localparam logic [1:0] KIND_OPEN     = 2'd1;
   localparam logic [1:0] KIND_CLOSE    = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   localparam logic [1:0] FLAGS_START = 2'd2;
   localparam logic [1:0] FLAGS_CONT  = 2'd1;

   typedef enum logic [3:0] {
      ST_NO_LINK   = 4'd0,
      ST_IGNORED   = 4'd1,
      ST_BAD_START = 4'd2,
      ST_STARTED   = 4'd3,
      ST_APPENDED  = 4'd4,
      ST_SINGLE    = 4'd5,
      ST_DONE      = 4'd6,
      ST_REJECTED  = 4'd7,
      ST_OPENED    = 4'd8,
      ST_FULL      = 4'd9,
      ST_CLOSED    = 4'd10,
      ST_UNKNOWN   = 4'd11
   } status_type;

   typedef enum logic [2:0] {
      OP_START,
      OP_CONT,
      OP_IGNORE,
      OP_OPEN,
      OP_CLOSE,
      OP_UNKNOWN
   } op_type;

   // One classified transaction as it travels from the front end to the back end.
   typedef struct packed {
      op_type      op;
      logic [11:0] handle;
      logic [15:0] len;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [15:0] start_len;
      logic        len_ge1;
      logic        len_ge2;
      logic        len_ge4;
   } work_item_type;

endpackage

// File: hw/rtl/acl_fr_front.sv
// Front end: accepts request transactions and classifies them into work items.
`timescale 1ns / 1ps

module acl_fr_front import acl_fr_pkg::*; (
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_kind,
   input  logic [11:0]   req_conn_handle,
   input  logic [1:0]    req_boundary_flags,
   input  logic [15:0]   req_acl_length,
   input  logic [7:0]    req_first_byte,
   input  logic [7:0]    req_second_byte,
   input  logic          q_full,
   output logic          q_push,
   output work_item_type q_item
);

   op_type op;

   always_comb begin
      unique case (req_kind)
         KIND_OPEN:     op = OP_OPEN;
         KIND_CLOSE:    op = OP_CLOSE;
         KIND_RESERVED: op = OP_UNKNOWN;
         default: begin
            priority if (req_boundary_flags == FLAGS_START) op = OP_START;
            else if (req_boundary_flags == FLAGS_CONT) op = OP_CONT;
            else op = OP_IGNORE;
         end
      endcase
   end

   always_comb begin
      q_item.op        = op;
      q_item.handle    = req_conn_handle;
      q_item.len       = req_acl_length;
      q_item.b0        = req_first_byte;
      q_item.b1        = req_second_byte;
      // L2CAP length plus its header, wrapping at 16 bits.
      q_item.start_len = {req_second_byte, req_first_byte} + L2_HDR_LEN;
      q_item.len_ge1   = (req_acl_length != 16'd0);
      q_item.len_ge2   = (req_acl_length >= 16'd2);
      q_item.len_ge4   = (req_acl_length >= L2_HDR_LEN);
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

// File: hw/rtl/acl_fr_queue.sv
// Short first-in first-out queue of work items between front and back end.
`timescale 1ns / 1ps
`include "acl_fragment_reassembly_unit_assert.svh"

module acl_fr_queue import acl_fr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  work_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output work_item_type head
);

   work_item_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      logic [QUEUE_PTR_W-1:0] r;
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) r = '0;
      else r = p + QUEUE_PTR_W'(1);
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      priority if (push && !pop) count_in = count_ff + QUEUE_CNT_W'(1);
      else if (pop && !push) count_in = count_ff - QUEUE_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   `AFR_ASSERT(a_count_bound, 1'b1, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count overrun")
   `AFR_ASSERT_NEXT(a_push_grows, push && !pop, count_ff == $past(count_ff) + QUEUE_CNT_W'(1), "queue push lost")
   `AFR_ASSERT(a_pop_nonempty, pop, count_ff != '0, "queue popped while empty")

endmodule

// File: hw/rtl/acl_fr_back.sv
// Back end: slot table lookup, reassembly state update and result register.
`timescale 1ns / 1ps
`include "acl_fragment_reassembly_unit_assert.svh"

module acl_fr_back import acl_fr_pkg::*; #(
   parameter int unsigned LINK_SLOTS = LINK_SLOTS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data,
   input  logic          q_valid,
   input  work_item_type q_item,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [3:0]    rsp_status,
   output logic [1:0]    rsp_slot,
   output logic [15:0]   rsp_write_offset,
   output logic [15:0]   rsp_total_length,
   output logic          rsp_aborted_previous
);

   localparam int unsigned SW = (LINK_SLOTS > 1) ? $clog2(LINK_SLOTS) : 1;

   logic [15:0] max_rx_len_ff, max_rx_len_in;

   logic        used_ff   [LINK_SLOTS];
   logic        used_in   [LINK_SLOTS];
   logic [11:0] link_ff   [LINK_SLOTS];
   logic [11:0] link_in   [LINK_SLOTS];
   logic        active_ff [LINK_SLOTS];
   logic        active_in [LINK_SLOTS];
   logic        known_ff  [LINK_SLOTS];
   logic        known_in  [LINK_SLOTS];
   logic [15:0] rem_ff    [LINK_SLOTS];
   logic [15:0] rem_in    [LINK_SLOTS];
   logic [15:0] gath_ff   [LINK_SLOTS];
   logic [15:0] gath_in   [LINK_SLOTS];
   logic [7:0]  hlo_ff    [LINK_SLOTS];
   logic [7:0]  hlo_in    [LINK_SLOTS];
   logic [7:0]  hhi_ff    [LINK_SLOTS];
   logic [7:0]  hhi_in    [LINK_SLOTS];

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [1:0]    rsp_slot_ff, rsp_slot_in;
   logic [15:0]   rsp_off_ff, rsp_off_in;
   logic [15:0]   rsp_tot_ff, rsp_tot_in;
   logic          rsp_ab_ff, rsp_ab_in;

   logic          match_hit, free_hit;
   logic [SW-1:0] match_idx, free_idx, sel;
   logic          cur_active, cur_known;
   logic [15:0]   cur_rem, cur_gath;
   logic [7:0]    cur_hlo, cur_hhi;

   logic [16:0]   off_len;
   logic [15:0]   gath_u, exp_u, rem_u, rem_k, tot_k;
   logic [7:0]    hlo_u, hhi_u;
   logic [SW+1:0] slot_wide;

   logic          wr_en, w_used, w_link_en, w_active, w_known;
   logic [15:0]   w_rem, w_gath;
   logic [7:0]    w_hlo, w_hhi;
   status_type    st;
   logic [SW-1:0] out_slot;
   logic [15:0]   out_off, out_tot;
   logic          out_ab;

   // Lowest used slot with a matching handle, and lowest free slot.
   always_comb begin
      match_hit = 1'b0;
      match_idx = '0;
      free_hit  = 1'b0;
      free_idx  = '0;
      for (int i = LINK_SLOTS - 1; i >= 0; i--) begin
         if (used_ff[i] && link_ff[i] == q_item.handle) begin
            match_hit = 1'b1;
            match_idx = SW'(i);
         end
         if (!used_ff[i]) begin
            free_hit = 1'b1;
            free_idx = SW'(i);
         end
      end
   end

   always_comb begin
      cur_active = active_ff[match_idx];
      cur_known  = known_ff[match_idx];
      cur_rem    = rem_ff[match_idx];
      cur_gath   = gath_ff[match_idx];
      cur_hlo    = hlo_ff[match_idx];
      cur_hhi    = hhi_ff[match_idx];

      // Continuation arithmetic, both for a known and an unknown length.
      off_len = {1'b0, cur_gath} + {1'b0, q_item.len};
      gath_u  = off_len[15:0];
      rem_k   = cur_rem - q_item.len;
      tot_k   = cur_gath + cur_rem;
      hlo_u   = cur_hlo;
      hhi_u   = cur_hhi;
      if (q_item.len_ge1) begin
         if (cur_gath == 16'd0) hlo_u = q_item.b0;
         else if (cur_gath == 16'd1) hhi_u = q_item.b0;
      end
      if (q_item.len_ge2 && cur_gath == 16'd0) hhi_u = q_item.b1;
      exp_u = {hhi_u, hlo_u} + L2_HDR_LEN;
      rem_u = exp_u - gath_u;
   end

   always_comb begin
      st        = ST_NO_LINK;
      out_slot  = '0;
      out_off   = '0;
      out_tot   = '0;
      out_ab    = 1'b0;
      sel       = match_idx;
      wr_en     = 1'b0;
      w_used    = 1'b1;
      w_link_en = 1'b0;
      w_active  = 1'b0;
      w_known   = 1'b0;
      w_rem     = '0;
      w_gath    = '0;
      w_hlo     = '0;
      w_hhi     = '0;

      unique case (q_item.op)
         OP_OPEN: begin
            if (free_hit) begin
               st        = ST_OPENED;
               sel       = free_idx;
               out_slot  = free_idx;
               wr_en     = 1'b1;
               w_link_en = 1'b1;
            end else begin
               st = ST_FULL;
            end
         end
         OP_UNKNOWN: st = ST_UNKNOWN;
         OP_CLOSE: begin
            if (match_hit) begin
               st       = ST_CLOSED;
               out_slot = match_idx;
               wr_en    = 1'b1;
               w_used   = 1'b0;
            end
         end
         OP_IGNORE: begin
            if (match_hit) begin
               st       = ST_IGNORED;
               out_slot = match_idx;
            end
         end
         OP_START: begin
            if (match_hit) begin
               out_slot = match_idx;
               out_ab   = cur_active;
               wr_en    = 1'b1;
               if (q_item.len_ge4) begin
                  priority if (q_item.start_len > max_rx_len_ff ||
                               q_item.start_len < q_item.len) begin
                     st = ST_BAD_START;
                  end else if (q_item.start_len == q_item.len) begin
                     st      = ST_SINGLE;
                     out_tot = q_item.start_len;
                  end else begin
                     st       = ST_STARTED;
                     out_tot  = q_item.start_len;
                     w_active = 1'b1;
                     w_known  = 1'b1;
                     w_rem    = q_item.start_len - q_item.len;
                     w_gath   = q_item.len;
                     w_hlo    = q_item.b0;
                     w_hhi    = q_item.b1;
                  end
               end else begin
                  st       = ST_STARTED;
                  w_active = 1'b1;
                  w_gath   = q_item.len;
                  w_hlo    = q_item.len_ge1 ? q_item.b0 : 8'd0;
                  w_hhi    = q_item.len_ge2 ? q_item.b1 : 8'd0;
               end
            end
         end
         OP_CONT: begin
            if (match_hit) begin
               out_slot = match_idx;
               priority if (!cur_active) begin
                  st = ST_IGNORED;
               end else if (cur_known) begin
                  wr_en = 1'b1;
                  priority if (q_item.len > cur_rem) begin
                     st = ST_REJECTED;
                  end else if (rem_k == 16'd0) begin
                     st      = ST_DONE;
                     out_off = cur_gath;
                     out_tot = tot_k;
                  end else begin
                     st       = ST_APPENDED;
                     out_off  = cur_gath;
                     out_tot  = tot_k;
                     w_active = 1'b1;
                     w_known  = 1'b1;
                     w_rem    = rem_k;
                     w_gath   = gath_u;
                     w_hlo    = cur_hlo;
                     w_hhi    = cur_hhi;
                  end
               end else begin
                  wr_en = 1'b1;
                  priority if (off_len > {1'b0, max_rx_len_ff}) begin
                     st = ST_REJECTED;
                  end else if (gath_u < L2_HDR_LEN) begin
                     st       = ST_APPENDED;
                     out_off  = cur_gath;
                     w_active = 1'b1;
                     w_rem    = cur_rem;
                     w_gath   = gath_u;
                     w_hlo    = hlo_u;
                     w_hhi    = hhi_u;
                  end else if (exp_u > max_rx_len_ff || exp_u < gath_u) begin
                     st = ST_REJECTED;
                  end else if (rem_u == 16'd0) begin
                     st      = ST_DONE;
                     out_off = cur_gath;
                     out_tot = exp_u;
                  end else begin
                     st       = ST_APPENDED;
                     out_off  = cur_gath;
                     out_tot  = exp_u;
                     w_active = 1'b1;
                     w_known  = 1'b1;
                     w_rem    = rem_u;
                     w_gath   = gath_u;
                     w_hlo    = hlo_u;
                     w_hhi    = hhi_u;
                  end
               end
            end
         end
         default: st = ST_UNKNOWN;
      endcase
   end

   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      for (int i = 0; i < LINK_SLOTS; i++) begin
         if (q_pop && wr_en && sel == SW'(i)) begin
            used_in[i]   = w_used;
            link_in[i]   = w_link_en ? q_item.handle : link_ff[i];
            active_in[i] = w_active;
            known_in[i]  = w_known;
            rem_in[i]    = w_rem;
            gath_in[i]   = w_gath;
            hlo_in[i]    = w_hlo;
            hhi_in[i]    = w_hhi;
         end else begin
            used_in[i]   = used_ff[i];
            link_in[i]   = link_ff[i];
            active_in[i] = active_ff[i];
            known_in[i]  = known_ff[i];
            rem_in[i]    = rem_ff[i];
            gath_in[i]   = gath_ff[i];
            hlo_in[i]    = hlo_ff[i];
            hhi_in[i]    = hhi_ff[i];
         end
      end
   end

   always_comb begin
      max_rx_len_in = max_rx_len_ff;
      if (csr_wr_en) begin
         max_rx_len_in = (csr_wr_data < MIN_RX_LEN) ? MIN_RX_LEN : csr_wr_data;
      end
   end

   assign slot_wide = {2'b00, out_slot};

   always_comb begin
      rsp_valid_in  = q_pop ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_status_in = q_pop ? st : rsp_status_ff;
      rsp_slot_in   = q_pop ? slot_wide[1:0] : rsp_slot_ff;
      rsp_off_in    = q_pop ? out_off : rsp_off_ff;
      rsp_tot_in    = q_pop ? out_tot : rsp_tot_ff;
      rsp_ab_in     = q_pop ? out_ab : rsp_ab_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rx_len_ff <= MIN_RX_LEN;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < LINK_SLOTS; i++) begin
            used_ff[i]   <= 1'b0;
            active_ff[i] <= 1'b0;
            known_ff[i]  <= 1'b0;
            rem_ff[i]    <= '0;
            gath_ff[i]   <= '0;
            hlo_ff[i]    <= '0;
            hhi_ff[i]    <= '0;
         end
      end else begin
         max_rx_len_ff <= max_rx_len_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int i = 0; i < LINK_SLOTS; i++) begin
            used_ff[i]   <= used_in[i];
            active_ff[i] <= active_in[i];
            known_ff[i]  <= known_in[i];
            rem_ff[i]    <= rem_in[i];
            gath_ff[i]   <= gath_in[i];
            hlo_ff[i]    <= hlo_in[i];
            hhi_ff[i]    <= hhi_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_tot_ff    <= rsp_tot_in;
      rsp_ab_ff     <= rsp_ab_in;
      for (int i = 0; i < LINK_SLOTS; i++) begin
         link_ff[i] <= link_in[i];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_write_offset     = rsp_off_ff;
   assign rsp_total_length     = rsp_tot_ff;
   assign rsp_aborted_previous = rsp_ab_ff;

   for (genvar g = 0; g < LINK_SLOTS; g++) begin : g_slot_chk
      `AFR_ASSERT(a_known_active, known_ff[g], active_ff[g], "length known on idle slot")
      `AFR_ASSERT(a_active_used, active_ff[g], used_ff[g], "reassembly on free slot")
   end

endmodule

// File: hw/rtl/acl_fragment_reassembly_unit.sv
// Top level of the ACL fragment reassembly unit.
`timescale 1ns / 1ps

// Channel   Direction  Handshake        Contents
// req_*     in         valid / stall    one fragment header, open or close request
// rsp_*     out        valid / stall    status, slot, write offset, total length
// csr_*     in         write enable     max_rx_len, clamped to at least 27
//
// The unit sustains one transaction per cycle while neither channel stalls; each accepted
// request is written into the queue, and the slot table is read and updated as it moves
// from the queue head into the result register. The rate is set by the slot table's
// read-modify-write. Reset is synchronous: all slots are freed, max_rx_len returns to 27
// and the queue empties; no clearing pass is needed. A stalled result holds in the output
// register while the queue absorbs up to two further requests before req_stall rises.

module acl_fragment_reassembly_unit import acl_fr_pkg::*; #(
   parameter int unsigned LINK_SLOTS = LINK_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [11:0] req_conn_handle,
   input  logic [1:0]  req_boundary_flags,
   input  logic [15:0] req_acl_length,
   input  logic [7:0]  req_first_byte,
   input  logic [7:0]  req_second_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [1:0]  rsp_slot,
   output logic [15:0] rsp_write_offset,
   output logic [15:0] rsp_total_length,
   output logic        rsp_aborted_previous,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // Classified transactions pass from the front end to the back end
   // through the queue, so a back end stall holds the front end only once the queue is full.
   logic          q_full;
   logic          q_push;
   work_item_type q_push_item;
   logic          q_pop;
   logic          q_not_empty;
   work_item_type q_head;

   // The front end decodes kind and boundary flags and works out the
   // start length, so the back end only has the slot table to deal with.
   acl_fr_front u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_conn_handle    (req_conn_handle),
      .req_boundary_flags (req_boundary_flags),
      .req_acl_length     (req_acl_length),
      .req_first_byte     (req_first_byte),
      .req_second_byte    (req_second_byte),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_item             (q_push_item)
   );

   acl_fr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // The back end owns the handle table, per-slot reassembly state, the
   // max_rx_len register and the result register.
   acl_fr_back #(
      .LINK_SLOTS (LINK_SLOTS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .q_valid              (q_not_empty),
      .q_item               (q_head),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_slot             (rsp_slot),
      .rsp_write_offset     (rsp_write_offset),
      .rsp_total_length     (rsp_total_length),
      .rsp_aborted_previous (rsp_aborted_previous)
   );

endmodule

// File: tb/acl_fragment_reassembly_unit_tb.sv
// Self-checking testbench for the ACL fragment reassembly unit.
`timescale 1ns / 1ps

module acl_fragment_reassembly_unit_tb;
   import acl_fr_pkg::*;

   // The tracker below mirrors the unit's slot table, so it is sized from the same default.
   localparam int unsigned TRACKED_SLOTS = LINK_SLOTS_DEFAULT;
   // Cycles without any accepted transaction before the run is declared hung.
   localparam int unsigned STALL_LIMIT   = 2000;
   // Settling time after the last result.
   localparam int unsigned SETTLE_CYCLES = 8;

   // What the unit is expected to report for one request transaction.
   typedef struct packed {
      status_type  status;
      logic [1:0]  slot;
      logic [15:0] offset;
      logic [15:0] total;
      logic        aborted;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = KIND_FRAGMENT;
   logic [11:0] req_conn_handle = '0;
   logic [1:0]  req_boundary_flags = '0;
   logic [15:0] req_acl_length = '0;
   logic [7:0]  req_first_byte = '0;
   logic [7:0]  req_second_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [1:0]  rsp_slot;
   logic [15:0] rsp_write_offset;
   logic [15:0] rsp_total_length;
   logic        rsp_aborted_previous;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // Tracker state: a copy of the slot table and the packet-size limit, kept in step with
   // every accepted request transaction and every register write.
   logic [15:0] rx_limit;
   logic        slot_open   [TRACKED_SLOTS];
   logic [11:0] slot_handle [TRACKED_SLOTS];
   logic        in_progress [TRACKED_SLOTS];
   logic        len_known   [TRACKED_SLOTS];
   logic [15:0] remaining   [TRACKED_SLOTS];
   logic [15:0] gathered    [TRACKED_SLOTS];
   logic [7:0]  hdr_lo      [TRACKED_SLOTS];
   logic [7:0]  hdr_hi      [TRACKED_SLOTS];

   outcome_type pending_outcomes[$];
   int unsigned mismatches = 0;
   int unsigned fragments_sent = 0;
   int unsigned quiet_cycles = 0;
   int unsigned send_idle_pct = 29;
   int unsigned rsp_idle_pct = 65;

   acl_fragment_reassembly_unit u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_conn_handle      (req_conn_handle),
      .req_boundary_flags   (req_boundary_flags),
      .req_acl_length       (req_acl_length),
      .req_first_byte       (req_first_byte),
      .req_second_byte      (req_second_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_slot             (rsp_slot),
      .rsp_write_offset     (rsp_write_offset),
      .rsp_total_length     (rsp_total_length),
      .rsp_aborted_previous (rsp_aborted_previous),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random; a percentage of zero gives an unbroken stream.
   always @(negedge clock) begin
      rsp_stall <= (rsp_idle_pct != 0) && ($urandom_range(99) < rsp_idle_pct);
   end

   // Drops any packet being gathered in a slot, leaving the handle itself in place.
   function automatic void clear_reassembly(input int s);
      in_progress[s] = 1'b0;
      len_known[s]   = 1'b0;
      remaining[s]   = '0;
      gathered[s]    = '0;
      hdr_lo[s]      = '0;
      hdr_hi[s]      = '0;
   endfunction

   function automatic void reset_tracker();
      rx_limit = MIN_RX_LEN;
      for (int s = 0; s < TRACKED_SLOTS; s++) begin
         slot_open[s]   = 1'b0;
         slot_handle[s] = '0;
         clear_reassembly(s);
      end
   endfunction

   // Works out the unit's answer to one request transaction and advances the tracker.
   function automatic outcome_type reassemble(input logic [1:0] kind, input logic [11:0] handle,
                                              input logic [1:0] flags, input logic [15:0] len,
                                              input logic [7:0] b0, input logic [7:0] b1);
      outcome_type res;
      int          s;
      int          i;
      int unsigned off;
      logic [15:0] hdr_len;
      res = '{status: ST_NO_LINK, slot: 2'd0, offset: 16'd0, total: 16'd0, aborted: 1'b0};
      s = -1;
      if (kind == KIND_OPEN) begin
         // An open never looks for the handle already being present: it simply takes the
         // lowest free slot and starts that slot afresh.
         res.status = ST_FULL;
         for (i = 0; i < TRACKED_SLOTS; i++) begin
            if (!slot_open[i]) begin
               slot_open[i]   = 1'b1;
               slot_handle[i] = handle;
               clear_reassembly(i);
               res.status = ST_OPENED;
               res.slot   = 2'(i);
               break;
            end
         end
         return res;
      end
      if (kind == KIND_RESERVED) begin
         res.status = ST_UNKNOWN;
         return res;
      end
      // Only open slots take part in the lookup, and the lowest match wins.
      for (i = 0; i < TRACKED_SLOTS; i++) begin
         if (slot_open[i] && slot_handle[i] == handle) begin
            s = i;
            break;
         end
      end
      if (s < 0) begin
         return res;
      end
      res.slot = 2'(s);
      if (kind == KIND_CLOSE) begin
         slot_open[s] = 1'b0;
         clear_reassembly(s);
         res.status = ST_CLOSED;
         return res;
      end

      if (flags == FLAGS_START) begin
         res.aborted = in_progress[s];
         clear_reassembly(s);
         if (len >= L2_HDR_LEN) begin
            hdr_len = {b1, b0} + L2_HDR_LEN;
            if (hdr_len > rx_limit || hdr_len < len) begin
               res.status = ST_BAD_START;
            end else if (hdr_len == len) begin
               res.status = ST_SINGLE;
               res.total  = hdr_len;
            end else begin
               in_progress[s] = 1'b1;
               len_known[s]   = 1'b1;
               remaining[s]   = hdr_len - len;
               gathered[s]    = len;
               hdr_lo[s]      = b0;
               hdr_hi[s]      = b1;
               res.status = ST_STARTED;
               res.total  = hdr_len;
            end
            return res;
         end
         // Too short to carry the whole L2CAP length: keep whatever header bytes came.
         in_progress[s] = 1'b1;
         gathered[s]    = len;
         if (len >= 1) hdr_lo[s] = b0;
         if (len >= 2) hdr_hi[s] = b1;
         res.status = ST_STARTED;
         return res;
      end

      if (flags != FLAGS_CONT || !in_progress[s]) begin
         res.status = ST_IGNORED;
         return res;
      end

      off = gathered[s];
      if (len_known[s]) begin
         if (len > remaining[s]) begin
            clear_reassembly(s);
            res.status = ST_REJECTED;
            return res;
         end
         res.offset   = 16'(off);
         res.total    = 16'(off + remaining[s]);
         gathered[s]  = 16'(off + len);
         remaining[s] = remaining[s] - len;
         if (remaining[s] == 0) begin
            clear_reassembly(s);
            res.status = ST_DONE;
         end else begin
            res.status = ST_APPENDED;
         end
         return res;
      end

      // Length still unknown: the limit alone bounds the packet until the header is complete.
      if (off + len > rx_limit) begin
         clear_reassembly(s);
         res.status = ST_REJECTED;
         return res;
      end
      if (len >= 1) begin
         if (off == 0) hdr_lo[s] = b0;
         else if (off == 1) hdr_hi[s] = b0;
      end
      if (len >= 2 && off == 0) hdr_hi[s] = b1;
      gathered[s] = 16'(off + len);
      res.offset  = 16'(off);
      if (gathered[s] < L2_HDR_LEN) begin
         res.status = ST_APPENDED;
         return res;
      end
      hdr_len = {hdr_hi[s], hdr_lo[s]} + L2_HDR_LEN;
      if (hdr_len > rx_limit || hdr_len < gathered[s]) begin
         clear_reassembly(s);
         res.status = ST_REJECTED;
         res.offset = '0;
         return res;
      end
      len_known[s] = 1'b1;
      remaining[s] = hdr_len - gathered[s];
      res.total    = hdr_len;
      if (remaining[s] == 0) begin
         clear_reassembly(s);
         res.status = ST_DONE;
      end else begin
         res.status = ST_APPENDED;
      end
      return res;
   endfunction

   // Drives one request transaction at a falling edge, possibly after some idle cycles, and
   // records its expected outcome at the rising edge that accepts it. Valid is left high on
   // return so that back-to-back transactions need no extra cycle.
   task automatic send_request(input logic [1:0] kind, input logic [11:0] handle,
                               input logic [1:0] flags, input logic [15:0] len,
                               input logic [7:0] b0, input logic [7:0] b1);
      outcome_type want;
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_kind           = kind;
      req_conn_handle    = handle;
      req_boundary_flags = flags;
      req_acl_length     = len;
      req_first_byte     = b0;
      req_second_byte    = b1;
      do @(posedge clock); while (req_stall);
      want = reassemble(kind, handle, flags, len, b0, b1);
      pending_outcomes.push_back(want);
      fragments_sent++;
   endtask

   // Lowers valid and holds off until every outstanding result has been returned.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // The register is only written with the unit idle, so the tracker follows it at once.
   task automatic write_rx_limit(input logic [15:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      rx_limit = (value < MIN_RX_LEN) ? MIN_RX_LEN : value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Picks the handle of a random open slot; returns 0 when the table is empty.
   function automatic bit pick_open_handle(output logic [11:0] handle);
      int used [TRACKED_SLOTS];
      int count;
      count  = 0;
      handle = '0;
      for (int s = 0; s < TRACKED_SLOTS; s++) begin
         if (slot_open[s]) begin
            used[count] = s;
            count++;
         end
      end
      if (count == 0) return 1'b0;
      handle = slot_handle[used[$urandom_range(0, count - 1)]];
      return 1'b1;
   endfunction

   // Payload byte at a given packet position: the L2CAP length for the first two, else random.
   function automatic logic [7:0] packet_byte(input int unsigned pos, input logic [15:0] hdr);
      if (pos == 0) return hdr[7:0];
      if (pos == 1) return hdr[15:8];
      return 8'($urandom_range(0, 255));
   endfunction

   // A transaction with random content: any kind, flags and length on a known or random handle.
   task automatic send_noise();
      logic [11:0] h;
      logic [1:0]  kind;
      logic [15:0] len;
      if (!pick_open_handle(h) || $urandom_range(3) == 0) h = 12'($urandom_range(0, 4095));
      kind = ($urandom_range(9) < 7) ? KIND_FRAGMENT : 2'($urandom_range(1, 3));
      len  = $urandom_range(1) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 8));
      send_request(kind, h, 2'($urandom_range(0, 3)), len, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
   endtask

   // One L2CAP packet split into a start fragment and continuations on an open link. Now and
   // then the length field is corrupted, a fragment overshoots or the packet is abandoned, and
   // unrelated transactions are slipped in between the fragments.
   task automatic send_packet();
      logic [11:0] h;
      logic [15:0] hdr;
      int unsigned payload;
      int unsigned total;
      int unsigned sent;
      int unsigned frag;
      int unsigned cap;
      if (!pick_open_handle(h)) begin
         send_request(KIND_OPEN, 12'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)),
                      16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
         return;
      end
      case ($urandom_range(9))
         0: payload = $urandom_range(0, 65535);
         1: payload = rx_limit - L2_HDR_LEN - 1 + $urandom_range(0, 2);
         default: payload = $urandom_range(0, 23);
      endcase
      if (payload > 65535) payload = 65535;
      hdr   = ($urandom_range(15) == 0) ? 16'($urandom_range(0, 65535)) : 16'(payload);
      total = payload + L2_HDR_LEN;

      cap = (total < 16) ? total : 16;
      if ($urandom_range(2) == 0) frag = $urandom_range(0, 3);
      else if ($urandom_range(1) == 0) frag = $urandom_range(4, cap);
      else frag = $urandom_range(0, total);
      if (frag > 65535) frag = 65535;
      send_request(KIND_FRAGMENT, h, FLAGS_START, 16'(frag), packet_byte(0, hdr),
                   packet_byte(1, hdr));
      sent = frag;

      while (sent < total) begin
         if ($urandom_range(9) == 0) send_noise();
         cap  = (total - sent < 12) ? total - sent : 12;
         frag = $urandom_range(1) ? $urandom_range(0, cap) : $urandom_range(1, total - sent);
         if ($urandom_range(19) == 0) frag = total - sent + $urandom_range(1, 3);
         if (frag > 65535) frag = 65535;
         send_request(KIND_FRAGMENT, h, FLAGS_CONT, 16'(frag), packet_byte(sent, hdr),
                      packet_byte(sent + 1, hdr));
         sent += frag;
         if ($urandom_range(29) == 0) break;
      end
   endtask

   // Opens, duplicate opens, closes of open links and the reserved kind, with full and
   // unknown-handle answers along the way.
   task automatic test_link_table();
      send_request(KIND_OPEN, 12'h000, FLAGS_START, 16'd0, 8'h00, 8'h00);
      send_request(KIND_OPEN, 12'hfff, FLAGS_CONT, 16'hffff, 8'hff, 8'hff);
      send_request(KIND_OPEN, 12'h5a5, FLAGS_START, 16'd0, 8'h00, 8'h00);
      send_request(KIND_OPEN, 12'h123, FLAGS_START, 16'd0, 8'h00, 8'h00);
      send_request(KIND_CLOSE, 12'h123, FLAGS_START, 16'd0, 8'h00, 8'h00);
      send_request(KIND_RESERVED, 12'h000, FLAGS_START, 16'd4, 8'h01, 8'h00);
      send_request(KIND_CLOSE, 12'hfff, FLAGS_START, 16'd0, 8'h00, 8'h00);
      // The handle is already present in the lowest slot; the open still claims a new slot.
      send_request(KIND_OPEN, 12'h000, FLAGS_START, 16'd0, 8'h00, 8'h00);
      send_request(KIND_CLOSE, 12'h000, FLAGS_START, 16'd0, 8'h00, 8'h00);
      send_request(KIND_OPEN, 12'hfff, FLAGS_START, 16'd0, 8'h00, 8'h00);
   endtask

   // Start fragments at the reset limit of 27: ignored flags, a complete single fragment,
   // both kinds of bad start (wrapped length and too long), and starts that abort a packet.
   task automatic test_start_cases();
      send_request(KIND_FRAGMENT, 12'h5a5, 2'd0, 16'd4, 8'h01, 8'h00);
      send_request(KIND_FRAGMENT, 12'h5a5, 2'd3, 16'd4, 8'h01, 8'h00);
      send_request(KIND_FRAGMENT, 12'h5a5, FLAGS_CONT, 16'd4, 8'h01, 8'h00);
      send_request(KIND_FRAGMENT, 12'h5a5, FLAGS_START, 16'd5, 8'h01, 8'h00);
      send_request(KIND_FRAGMENT, 12'h5a5, FLAGS_START, 16'd4, 8'hff, 8'hff);
      send_request(KIND_FRAGMENT, 12'h5a5, FLAGS_START, 16'd4, 8'd24, 8'h00);
      send_request(KIND_FRAGMENT, 12'h5a5, FLAGS_START, 16'd6, 8'd23, 8'h00);
      send_request(KIND_FRAGMENT, 12'h5a5, FLAGS_START, 16'd2, 8'd10, 8'h00);
      send_request(KIND_FRAGMENT, 12'h5a5, FLAGS_START, 16'd0, 8'h00, 8'h00);
   endtask

   // Continuations: the length learned a byte at a time, appends, completion, overflow of a
   // known length, a learned length that wraps, and overflow of the limit while unknown.
   task automatic test_continuation_cases();
      send_request(KIND_FRAGMENT, 12'h000, FLAGS_START, 16'd0, 8'h00, 8'h00);
      send_request(KIND_FRAGMENT, 12'h000, FLAGS_CONT, 16'd1, 8'd5, 8'hff);
      send_request(KIND_FRAGMENT, 12'h000, FLAGS_CONT, 16'd2, 8'h00, 8'hff);
      send_request(KIND_FRAGMENT, 12'h000, FLAGS_CONT, 16'd3, 8'h77, 8'h88);
      send_request(KIND_FRAGMENT, 12'h000, FLAGS_CONT, 16'd4, 8'h77, 8'h88);
      send_request(KIND_FRAGMENT, 12'h000, FLAGS_START, 16'd4, 8'd10, 8'h00);
      send_request(KIND_FRAGMENT, 12'h000, FLAGS_CONT, 16'd0, 8'h00, 8'h00);
      send_request(KIND_FRAGMENT, 12'h000, FLAGS_CONT, 16'd10, 8'h55, 8'haa);
      send_request(KIND_FRAGMENT, 12'hfff, FLAGS_START, 16'd3, 8'hff, 8'hff);
      send_request(KIND_FRAGMENT, 12'hfff, FLAGS_CONT, 16'd1, 8'h00, 8'h00);
      send_request(KIND_FRAGMENT, 12'hfff, FLAGS_START, 16'd1, 8'd2, 8'h00);
      send_request(KIND_FRAGMENT, 12'hfff, FLAGS_CONT, 16'd27, 8'h00, 8'h00);
      send_request(KIND_FRAGMENT, 12'hfff, FLAGS_START, 16'd0, 8'h00, 8'h00);
      send_request(KIND_FRAGMENT, 12'hfff, FLAGS_CONT, 16'd2, 8'd3, 8'h00);
      send_request(KIND_CLOSE, 12'hfff, FLAGS_CONT, 16'd0, 8'h00, 8'h00);
   endtask

   // One phase of random traffic under a given limit and idling pattern. Most of it is
   // well-formed packets with random content; the rest is noise, link churn and the odd
   // pause until the unit has caught up completely.
   task automatic test_random_traffic(input int unsigned n_items, input int unsigned send_pct,
                                      input int unsigned recv_pct, input logic [15:0] limit);
      int unsigned target;
      int unsigned pick;
      logic [11:0] h;
      write_rx_limit(limit);
      send_idle_pct = send_pct;
      rsp_idle_pct  = recv_pct;
      target = fragments_sent + n_items;
      while (fragments_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_packet();
         end else if (pick < 92) begin
            send_noise();
         end else if (pick < 94) begin
            drain_results();
         end else if (pick < 97 && pick_open_handle(h)) begin
            send_request(KIND_CLOSE, h, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(1) == 0 || !pick_open_handle(h)) h = 12'($urandom_range(0, 4095));
            send_request(KIND_OPEN, h, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic check_field(input string field, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Every result transaction is matched against the oldest outstanding expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t ns: result with nothing outstanding, expected none, actual status %0d",
                     $time, rsp_status);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("slot", want.slot, rsp_slot);
            check_field("write_offset", want.offset, rsp_write_offset);
            check_field("total_length", want.total, rsp_total_length);
            check_field("aborted_previous", want.aborted, rsp_aborted_previous);
         end
      end
   end

   // Hang detection: any long run of cycles in which neither channel moves a transaction
   // ends the simulation as a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset_tracker();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed cases run at the reset limit, with the sender idling lightly and the
      // receiver heavily.
      test_link_table();
      test_start_cases();
      test_continuation_cases();

      // Random phases: lowest limit (a write of zero is raised to 27), then the largest
      // limit with the idling reversed, then a mid-range limit with no idling at all.
      test_random_traffic(200, 29, 65, 16'd0);
      test_random_traffic(200, 65, 29, 16'hffff);
      test_random_traffic(200, 0, 0, 16'($urandom_range(27, 600)));

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
